FILE: rtl/gf2_191_field_alu_assert.svh
// ============================================================================
// GF(2^191) field ALU assertion macros
// Implication checks sampled on the rising clock edge, muted during reset.
// ============================================================================
`ifndef GF2_191_FIELD_ALU_ASSERT_SVH
`define GF2_191_FIELD_ALU_ASSERT_SVH

// Same-cycle implication.
`define GFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gfa_pkg.sv
// ============================================================================
// GF(2^191) field ALU package
// Field constants, word types, opcodes, status codes and the squarer.
// ============================================================================
package gfa_pkg;

    localparam int FIELD_BITS = 191;
    localparam int TAIL_EXP   = 9;
    localparam int DIGIT      = 4;
    localparam int NUM_DIGITS = (FIELD_BITS + DIGIT - 1) / DIGIT;
    localparam int CNT_W      = $clog2(FIELD_BITS);
    localparam int DCNT_W     = $clog2(NUM_DIGITS);

    typedef logic [FIELD_BITS-1:0] elem_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_MUL = 3'd1,
        OP_SQR = 3'd2,
        OP_POW = 3'd3,
        OP_INV = 3'd4,
        OP_TRC = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INV_ZERO  = 2'd1,
        STATUS_ZERO_ZERO = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_WAIT,
        ST_POW_BIT,
        ST_POW_MUL,
        ST_INV_SQR,
        ST_INV_MUL,
        ST_TRACE,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] operand_a_low;
        logic [63:0] operand_a_mid;
        logic [62:0] operand_a_high;
        logic [63:0] operand_b_low;
        logic [63:0] operand_b_mid;
        logic [62:0] operand_b_high;
    } cmd_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_mid;
        logic [62:0] result_high;
        logic        trace_bit;
        logic [1:0]  status;
    } rsp_t;

    // Reduce a double-width product modulo x^191 + x^9 + 1 in two folds.
    function automatic elem_t gfa_reduce(input logic [2*FIELD_BITS-2:0] c);
        logic [FIELD_BITS-2:0]          h;
        logic [FIELD_BITS+TAIL_EXP-1:0] t;
        logic [TAIL_EXP-1:0]            h2;
        elem_t                          r;
        h = c[2*FIELD_BITS-2:FIELD_BITS];
        t = '0;
        t[FIELD_BITS-1:0] = c[FIELD_BITS-1:0];
        t[FIELD_BITS-2:0] = t[FIELD_BITS-2:0] ^ h;
        t[FIELD_BITS+TAIL_EXP-2:TAIL_EXP] = t[FIELD_BITS+TAIL_EXP-2:TAIL_EXP] ^ h;
        h2 = t[FIELD_BITS+TAIL_EXP-1:FIELD_BITS];
        r = t[FIELD_BITS-1:0];
        r[TAIL_EXP-1:0] = r[TAIL_EXP-1:0] ^ h2;
        r[2*TAIL_EXP-1:TAIL_EXP] = r[2*TAIL_EXP-1:TAIL_EXP] ^ h2;
        return r;
    endfunction

    // Squaring is linear: spread the bits apart, then reduce.
    function automatic elem_t gfa_sqr(input elem_t a);
        logic [2*FIELD_BITS-2:0] c;
        c = '0;
        for (int i = 0; i < FIELD_BITS; i++)
        begin
            c[2*i] = a[i];
        end
        return gfa_reduce(c);
    endfunction

endpackage

FILE: rtl/gfa_mul.sv
// ============================================================================
// GF(2^191) digit-serial multiplier
// Most significant digit first, four bits of B per cycle, reduced each step.
// ============================================================================
module gfa_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  gfa_pkg::elem_t a,
    input  gfa_pkg::elem_t b,
    output logic          done,
    output gfa_pkg::elem_t product
);
    import gfa_pkg::*;

    localparam int BW = NUM_DIGITS * DIGIT;
    localparam int PW = FIELD_BITS + DIGIT;

    elem_t          acc_reg, acc_next;
    elem_t          a_reg;
    logic [BW-1:0]  b_reg;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;
    logic [DIGIT-1:0] dig;
    logic [PW-1:0]  p;
    logic [DIGIT-1:0] top;
    elem_t          fold;

    always_comb
    begin
        dig = b_reg[BW-1:BW-DIGIT];
        p = {acc_reg, {DIGIT{1'b0}}};
        for (int j = 0; j < DIGIT; j++)
        begin
            if (dig[j])
            begin
                p = p ^ ({{DIGIT{1'b0}}, a_reg} << j);
            end
        end
        top = p[PW-1:FIELD_BITS];
        fold = '0;
        fold[DIGIT-1:0] = top;
        fold[TAIL_EXP+DIGIT-1:TAIL_EXP] = top;
        acc_next  = run_reg ? (p[FIELD_BITS-1:0] ^ fold) : acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(NUM_DIGITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
            b_reg <= {{(BW-FIELD_BITS){1'b0}}, b};
        end
        else if (run_reg)
        begin
            b_reg <= b_reg << DIGIT;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/gf2_191_field_alu.sv
// ============================================================================
// GF(2^191) field ALU
// Add, multiply, square, power, inverse and trace over x^191 + x^9 + 1,
// driven by a sequencer around one shared digit-serial multiplier.
// ============================================================================
//  channel   ports            direction  handshake
//  command   start, cmd       in         taken when start is high, busy low
//  response  done, rsp        out        one-cycle strobe, cannot be held off
//
// Add, square and unused opcodes go straight to the finish state; multiply
// waits for the multiplier, and trace, power and inverse are sequenced.
// Power and inverse run on the 48-step multiplier; squaring is a
// combinational linear map.
// Reset is asynchronous and active low and clears the sequencer only.
// The result strobe rises in the cycle in which busy falls, and a new
// command may be taken in that cycle.
module gf2_191_field_alu (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  gfa_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output gfa_pkg::rsp_t rsp
);
    import gfa_pkg::*;
    `include "gf2_191_field_alu_assert.svh"

    state_t     state_reg, state_next;
    opcode_t    op_reg, op_next;
    status_t    st_reg, st_next;
    elem_t      a_reg, a_next;
    elem_t      e_reg, e_next;
    elem_t      r_reg, r_next;
    elem_t      base_reg, base_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;
    rsp_t       rsp_reg, rsp_next;

    elem_t      in_a, in_b, sq_r, sq_base, mul_p;
    elem_t      mul_a, mul_b;
    logic       mul_start, mul_done;
    logic       accept;

    assign in_a   = {cmd.operand_a_high, cmd.operand_a_mid, cmd.operand_a_low};
    assign in_b   = {cmd.operand_b_high, cmd.operand_b_mid, cmd.operand_b_low};
    assign sq_r    = gfa_sqr(r_reg);
    assign sq_base = gfa_sqr(base_reg);
    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);

    gfa_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.opcode == OP_MUL)
                        state_next = ST_MUL_WAIT;
                    else if (cmd.opcode == OP_POW && in_a != '0)
                        state_next = ST_POW_BIT;
                    else if (cmd.opcode == OP_INV && in_a != '0)
                        state_next = ST_INV_SQR;
                    else if (cmd.opcode == OP_TRC)
                        state_next = ST_TRACE;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_MUL_WAIT:
                if (mul_done) state_next = ST_FIN;
            ST_POW_BIT:
            begin
                if (e_reg[0])
                    state_next = ST_POW_MUL;
                else if (cnt_reg == CNT_W'(FIELD_BITS - 1))
                    state_next = ST_FIN;
            end
            ST_POW_MUL:
            begin
                if (mul_done)
                    state_next = (cnt_reg == CNT_W'(FIELD_BITS - 1)) ? ST_FIN : ST_POW_BIT;
            end
            ST_INV_SQR:
                state_next = (cnt_reg == CNT_W'(FIELD_BITS - 1)) ? ST_FIN : ST_INV_MUL;
            ST_INV_MUL:
                if (mul_done) state_next = ST_INV_SQR;
            ST_TRACE:
                if (cnt_reg == CNT_W'(FIELD_BITS - 1)) state_next = ST_FIN;
            ST_FIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and multiplier control.
    always_comb
    begin
        op_next   = op_reg;
        st_next   = st_reg;
        a_next    = a_reg;
        e_next    = e_reg;
        r_next    = r_reg;
        base_next = base_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        mul_start = 1'b0;
        mul_a     = in_a;
        mul_b     = in_b;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = opcode_t'(cmd.opcode);
                    st_next   = STATUS_OK;
                    a_next    = in_a;
                    e_next    = in_b;
                    base_next = in_a;
                    cnt_next  = CNT_W'(1);
                    r_next    = '0;
                    unique case (cmd.opcode)
                        OP_ADD: r_next = in_a ^ in_b;
                        OP_MUL: mul_start = 1'b1;
                        OP_SQR: r_next = gfa_sqr(in_a);
                        OP_POW:
                        begin
                            cnt_next = '0;
                            if (in_a != '0)
                                r_next = elem_t'(1);
                            else if (in_b == '0)
                                st_next = STATUS_ZERO_ZERO;
                        end
                        OP_INV:
                        begin
                            r_next = in_a;
                            if (in_a == '0)
                                st_next = STATUS_INV_ZERO;
                        end
                        OP_TRC: r_next = in_a;
                        default: r_next = '0;
                    endcase
                end
            end
            ST_MUL_WAIT:
                if (mul_done) r_next = mul_p;
            ST_POW_BIT:
            begin
                mul_a = r_reg;
                mul_b = base_reg;
                if (e_reg[0])
                    mul_start = 1'b1;
                else
                begin
                    base_next = sq_base;
                    e_next    = e_reg >> 1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_POW_MUL:
            begin
                if (mul_done)
                begin
                    r_next    = mul_p;
                    base_next = sq_base;
                    e_next    = e_reg >> 1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_INV_SQR:
            begin
                r_next = sq_r;
                mul_a  = sq_r;
                mul_b  = a_reg;
                if (cnt_reg != CNT_W'(FIELD_BITS - 1))
                    mul_start = 1'b1;
            end
            ST_INV_MUL:
            begin
                if (mul_done)
                begin
                    r_next   = mul_p;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TRACE:
            begin
                // base walks the successive squarings, r accumulates them.
                base_next = sq_base;
                r_next    = r_reg ^ sq_base;
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_FIN:
            begin
                done_next = 1'b1;
                rsp_next.status = st_reg;
                if (op_reg == OP_TRC)
                begin
                    rsp_next.trace_bit   = r_reg[0];
                    rsp_next.result_low  = '0;
                    rsp_next.result_mid  = '0;
                    rsp_next.result_high = '0;
                end
                else
                begin
                    rsp_next.trace_bit   = 1'b0;
                    rsp_next.result_low  = r_reg[63:0];
                    rsp_next.result_mid  = r_reg[127:64];
                    rsp_next.result_high = r_reg[FIELD_BITS-1:128];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        st_reg   <= st_next;
        a_reg    <= a_next;
        e_reg    <= e_next;
        r_reg    <= r_next;
        base_reg <= base_next;
        cnt_reg  <= cnt_next;
        rsp_reg  <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `GFA_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while sequencer busy")
    `GFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `GFA_ASSERT_SAME(a_inv_zero, done && rsp.status == STATUS_INV_ZERO,
        rsp.result_low == '0 && rsp.result_mid == '0 && rsp.result_high == '0,
        "inverse of zero returned a nonzero value")

endmodule
